[rtl/core/bcs_pkg.sv]
`timescale 1ns / 1ps
package bcs_pkg;

  localparam int DATA_WIDTH = 32;
  localparam int COEF_WIDTH = 64;
  localparam int CFG_IDX_WIDTH = 8;

  // 1/sqrt3 as unsigned Q0.32
  localparam logic [63:0] RSQRT3_Q32 = 64'd2479700525;
  localparam logic signed [63:0] COEF_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] RECIP_LIMIT = 64'h4000_0000_0000_0000;

  typedef enum logic [CFG_IDX_WIDTH-1:0] {
    REG_VOLTAGE_RE = 8'd0,
    REG_VOLTAGE_IM = 8'd1,
    REG_POWER_RE   = 8'd2,
    REG_POWER_IM   = 8'd3
  } bcs_reg_e;

  typedef enum logic [2:0] {
    SQ_IDLE,
    SQ_LOAD,
    SQ_MUL,
    SQ_DIV,
    SQ_STORE
  } bcs_seq_e;

  // coefficient program, one product or one quotient per step
  typedef enum logic [3:0] {
    ST_VRR, ST_VII, ST_DIVA, ST_DIVB, ST_KA, ST_KB, ST_SKR, ST_SKI,
    ST_AA, ST_BB, ST_AB, ST_P0, ST_P1, ST_Q0, ST_Q1
  } bcs_step_e;

  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] psens_00;
    logic signed [DATA_WIDTH-1:0] psens_01;
    logic signed [DATA_WIDTH-1:0] psens_10;
    logic signed [DATA_WIDTH-1:0] psens_11;
    logic signed [DATA_WIDTH-1:0] vsens_00;
    logic signed [DATA_WIDTH-1:0] vsens_01;
    logic signed [DATA_WIDTH-1:0] vsens_10;
    logic signed [DATA_WIDTH-1:0] vsens_11;
    logic                         last_leaf_in;
  } bcs_in_t;

  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] isens_00;
    logic signed [DATA_WIDTH-1:0] isens_01;
    logic signed [DATA_WIDTH-1:0] isens_10;
    logic signed [DATA_WIDTH-1:0] isens_11;
    logic                         last_leaf_out;
    logic                         zero_voltage;
  } bcs_out_t;

  typedef struct packed {
    logic signed [COEF_WIDTH-1:0] ka;
    logic signed [COEF_WIDTH-1:0] kb;
    logic signed [COEF_WIDTH-1:0] p;
    logic signed [COEF_WIDTH-1:0] q;
    logic signed [COEF_WIDTH-1:0] ka_neg;
    logic signed [COEF_WIDTH-1:0] p_neg;
    logic                         zero;
  } bcs_coef_t;

  // symmetric saturation of a 128-bit value to +-(2^63-1)
  function automatic logic signed [63:0] bcs_sat64(input logic signed [127:0] x);
    logic signed [63:0] r;
    if (x > 128'(COEF_MAX)) begin
      r = COEF_MAX;
    end else if (x < -128'(COEF_MAX)) begin
      r = -COEF_MAX;
    end else begin
      r = x[63:0];
    end
    return r;
  endfunction

endpackage

[rtl/core/branch_current_sensitivity_top.sv]
`timescale 1ns / 1ps
// Channel | Direction | Handshake             | Payload
// in      | input     | in_valid_i/in_stall_o | in_data_i  (bcs_in_t)
// out     | output    | out_valid_o/out_stall_i | out_data_o (bcs_out_t)
// cfg     | input     | cfg_valid_i/cfg_ready_o | cfg_index_i, cfg_data_i
//
// Throughput is one transfer per cycle while neither the busy sequencer nor a stalled
// output holds the input; a result passes the input register, partial products,
// product merge, sum and saturate registers. After reset and after each write to a
// known register the coefficient sequencer runs one shared bit-serial multiplier and
// a radix-2 divider, skipping the remaining steps when |V| is zero. The input stalls
// meanwhile. A stalled output that holds a result freezes the whole pipeline.
module branch_current_sensitivity_top (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  bcs_pkg::bcs_in_t                  in_data_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output bcs_pkg::bcs_out_t                 out_data_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [bcs_pkg::CFG_IDX_WIDTH-1:0] cfg_index_i,
  input  logic [bcs_pkg::DATA_WIDTH-1:0]    cfg_data_i
);
  import bcs_pkg::*;

  localparam int NTERM = 16;
  localparam logic signed [97:0] OUT_MAX = 98'sd2147483647;
  localparam logic signed [97:0] OUT_MIN = -98'sd2147483648;

  bcs_coef_t coef;
  logic      busy;
  logic      en, accept;

  // stage valids and the last-leaf mark travel together
  logic v0_q, v1_q, v2_q, v3_q, out_valid_q;
  logic ll1_q, ll2_q, ll3_q;
  bcs_in_t s0_q;

  logic signed [DATA_WIDTH-1:0] a_in [4];
  logic signed [DATA_WIDTH-1:0] b_in [4];
  logic signed [COEF_WIDTH-1:0] g [4];
  logic signed [COEF_WIDTH-1:0] h [4];
  logic signed [COEF_WIDTH-1:0] cf [NTERM];
  logic signed [DATA_WIDTH-1:0] xv [NTERM];

  logic signed [63:0] pp_hi_d [NTERM];
  logic signed [63:0] pp_hi_q [NTERM];
  logic signed [64:0] pp_lo_d [NTERM];
  logic signed [64:0] pp_lo_q [NTERM];
  logic signed [95:0] prod_d [NTERM];
  logic signed [95:0] prod_q [NTERM];
  logic signed [97:0] sum_d [4];
  logic signed [97:0] sum_q [4];
  logic signed [97:0] sh [4];
  logic signed [DATA_WIDTH-1:0] res [4];
  bcs_out_t out_d, out_q;

  bcs_coef u_coef (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .busy_o      (busy),
    .coef_o      (coef)
  );

  assign cfg_ready_o = 1'b1;

  // advance every stage together unless the output holds a stalled result
  assign en         = !out_valid_q || !out_stall_i;
  assign in_stall_o = !en || busy;
  assign accept     = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q        <= 1'b0;
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      v3_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      v0_q        <= accept;
      v1_q        <= v0_q;
      v2_q        <= v1_q;
      v3_q        <= v2_q;
      out_valid_q <= v3_q;
    end
  end

  // stage 0: capture the transfer
  always_ff @(posedge clk_i) begin
    if (en && accept) begin
      s0_q <= in_data_i;
    end
  end

  // stage 1: each 64-bit coefficient times a 32-bit entry as two 32x32 halves
  always_comb begin
    a_in[0] = s0_q.psens_00;  a_in[1] = s0_q.psens_01;
    a_in[2] = s0_q.psens_10;  a_in[3] = s0_q.psens_11;
    b_in[0] = s0_q.vsens_00;  b_in[1] = s0_q.vsens_01;
    b_in[2] = s0_q.vsens_10;  b_in[3] = s0_q.vsens_11;
    g[0] = coef.ka;  g[1] = coef.kb;  g[2] = coef.kb;  g[3] = coef.ka_neg;
    h[0] = coef.p;   h[1] = coef.q;   h[2] = coef.q;   h[3] = coef.p_neg;
    for (int o = 0; o < 4; o++) begin
      cf[4*o]     = g[2*(o >> 1)];
      xv[4*o]     = a_in[o & 1];
      cf[4*o + 1] = g[2*(o >> 1) + 1];
      xv[4*o + 1] = a_in[2 + (o & 1)];
      cf[4*o + 2] = h[2*(o >> 1)];
      xv[4*o + 2] = b_in[o & 1];
      cf[4*o + 3] = h[2*(o >> 1) + 1];
      xv[4*o + 3] = b_in[2 + (o & 1)];
    end
    for (int k = 0; k < NTERM; k++) begin
      pp_hi_d[k] = $signed(cf[k][63:32]) * xv[k];
      pp_lo_d[k] = $signed({1'b0, cf[k][31:0]}) * xv[k];
    end
  end

  // stage 2: merge halves into the full product
  always_comb begin
    for (int k = 0; k < NTERM; k++) begin
      prod_d[k] = $signed({pp_hi_q[k], 32'd0}) + 96'(pp_lo_q[k]);
    end
  end

  // stage 3: four products per element
  always_comb begin
    for (int o = 0; o < 4; o++) begin
      sum_d[o] = 98'(prod_q[4*o]) + 98'(prod_q[4*o + 1])
               + 98'(prod_q[4*o + 2]) + 98'(prod_q[4*o + 3]);
    end
  end

  // stage 4: drop 24 fraction bits, saturate, force zero for a zero voltage
  always_comb begin
    for (int o = 0; o < 4; o++) begin
      sh[o] = sum_q[o] >>> 24;
      if (coef.zero) begin
        res[o] = '0;
      end else if (sh[o] > OUT_MAX) begin
        res[o] = OUT_MAX[DATA_WIDTH-1:0];
      end else if (sh[o] < OUT_MIN) begin
        res[o] = OUT_MIN[DATA_WIDTH-1:0];
      end else begin
        res[o] = sh[o][DATA_WIDTH-1:0];
      end
    end
    out_d.isens_00      = res[0];
    out_d.isens_01      = res[1];
    out_d.isens_10      = res[2];
    out_d.isens_11      = res[3];
    out_d.last_leaf_out = ll3_q;
    out_d.zero_voltage  = coef.zero;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      pp_hi_q <= pp_hi_d;
      pp_lo_q <= pp_lo_d;
      ll1_q   <= s0_q.last_leaf_in;
      prod_q  <= prod_d;
      ll2_q   <= ll1_q;
      sum_q   <= sum_d;
      ll3_q   <= ll2_q;
      out_q   <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // a zero voltage result carries all-zero elements
  a_zero_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.zero_voltage |->
      out_data_o.isens_00 == '0 && out_data_o.isens_01 == '0 &&
      out_data_o.isens_10 == '0 && out_data_o.isens_11 == '0)
    else $error("zero voltage result with nonzero elements");

  // a known register write restarts the coefficient sequencer
  a_cfg_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i && cfg_ready_o &&
      (cfg_index_i == REG_VOLTAGE_RE || cfg_index_i == REG_VOLTAGE_IM ||
       cfg_index_i == REG_POWER_RE || cfg_index_i == REG_POWER_IM)
      |=> busy && in_stall_o)
    else $error("register write did not restart coefficients");

  // the last stage always lands in the output register when enabled
  a_stage_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v3_q && en |=> out_valid_o)
    else $error("pipeline lost an item");

endmodule

[rtl/core/bcs_coef.sv]
`timescale 1ns / 1ps
module bcs_coef (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_valid_i,
  input  logic [bcs_pkg::CFG_IDX_WIDTH-1:0]   cfg_index_i,
  input  logic [bcs_pkg::DATA_WIDTH-1:0]      cfg_data_i,
  output logic                                busy_o,
  output bcs_pkg::bcs_coef_t                  coef_o
);
  import bcs_pkg::*;

  localparam logic [6:0] MUL_LAST = 7'd63;
  localparam logic [6:0] DIV_LAST = 7'd127;

  logic signed [31:0] vr_q, vi_q, sr_q, si_q;
  bcs_seq_e  state_q, state_d;
  bcs_step_e step_q, step_d;
  logic [6:0]   cnt_q, cnt_d;
  logic [127:0] prod_q, prod_d;
  logic [63:0]  mx_q, mx_d, rem_q, rem_d, quo_q, quo_d, n_q, n_d;
  logic         neg_q, neg_d, zero_q, zero_d;
  logic signed [127:0] acc_q, acc_d;
  logic signed [63:0] a_q, a_d, b_q, b_d, ka_q, ka_d, kb_q, kb_d;
  logic signed [63:0] skr_q, skr_d, ski_q, ski_d, c_q, c_d, d_q, d_d;
  logic signed [63:0] p_q, p_d, q_q, q_d;

  logic               cfg_hit;
  logic signed [63:0] op_x, op_y;
  logic [63:0]        mag_x, mag_y;
  logic               is_div;
  logic [64:0]        mul_sum, div_rem;
  logic signed [127:0] prod_s;
  logic [63:0]        quo_c;
  logic signed [63:0] quo_s;

  always_comb begin
    cfg_hit = 1'b0;
    unique case (cfg_index_i)
      REG_VOLTAGE_RE, REG_VOLTAGE_IM, REG_POWER_RE, REG_POWER_IM: cfg_hit = cfg_valid_i;
      default: cfg_hit = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vr_q <= 32'sd65536;
      vi_q <= '0;
      sr_q <= '0;
      si_q <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_VOLTAGE_RE: vr_q <= cfg_data_i;
        REG_VOLTAGE_IM: vi_q <= cfg_data_i;
        REG_POWER_RE:   sr_q <= cfg_data_i;
        REG_POWER_IM:   si_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // operand select for the current step
  always_comb begin
    op_x   = '0;
    op_y   = '0;
    is_div = 1'b0;
    unique case (step_q)
      ST_VRR:  begin op_x = 64'(vr_q);  op_y = 64'(vr_q); end
      ST_VII:  begin op_x = 64'(vi_q);  op_y = 64'(vi_q); end
      ST_DIVA: begin op_x = 64'(vr_q);  is_div = 1'b1; end
      ST_DIVB: begin op_x = 64'(vi_q);  is_div = 1'b1; end
      ST_KA:   begin op_x = a_q;   op_y = RSQRT3_Q32; end
      ST_KB:   begin op_x = b_q;   op_y = RSQRT3_Q32; end
      ST_SKR:  begin op_x = 64'(sr_q);  op_y = RSQRT3_Q32; end
      ST_SKI:  begin op_x = 64'(si_q);  op_y = RSQRT3_Q32; end
      ST_AA:   begin op_x = a_q;   op_y = a_q; end
      ST_BB:   begin op_x = b_q;   op_y = b_q; end
      ST_AB:   begin op_x = a_q;   op_y = b_q; end
      ST_P0:   begin op_x = skr_q; op_y = c_q; end
      ST_P1:   begin op_x = ski_q; op_y = d_q; end
      ST_Q0:   begin op_x = ski_q; op_y = c_q; end
      ST_Q1:   begin op_x = skr_q; op_y = d_q; end
      default: ;
    endcase
    mag_x = op_x[63] ? -op_x : op_x;
    mag_y = op_y[63] ? -op_y : op_y;
  end

  assign mul_sum = {1'b0, prod_q[127:64]} + (prod_q[0] ? {1'b0, mx_q} : 65'd0);
  assign div_rem = {rem_q, prod_q[127]};
  assign prod_s  = neg_q ? -$signed(prod_q) : $signed(prod_q);
  assign quo_c   = (quo_q > RECIP_LIMIT) ? RECIP_LIMIT : quo_q;
  assign quo_s   = neg_q ? -$signed(quo_c) : $signed(quo_c);

  // next state
  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    if (cfg_hit) begin
      state_d = SQ_LOAD;
      step_d  = ST_VRR;
    end else begin
      unique case (state_q)
        SQ_IDLE: ;
        SQ_LOAD: state_d = is_div ? SQ_DIV : SQ_MUL;
        SQ_MUL:  if (cnt_q == MUL_LAST) state_d = SQ_STORE;
        SQ_DIV:  if (cnt_q == DIV_LAST) state_d = SQ_STORE;
        SQ_STORE: begin
          if ((step_q == ST_VII && n_d == '0) || step_q == ST_Q1) begin
            state_d = SQ_IDLE;
          end else begin
            state_d = SQ_LOAD;
            step_d  = bcs_step_e'(step_q + 4'd1);
          end
        end
        default: state_d = SQ_IDLE;
      endcase
    end
  end

  // datapath
  always_comb begin
    cnt_d  = cnt_q;
    prod_d = prod_q;
    mx_d   = mx_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    neg_d  = neg_q;
    n_d    = n_q;
    zero_d = zero_q;
    acc_d  = acc_q;
    a_d = a_q;   b_d = b_q;   ka_d = ka_q;   kb_d = kb_q;
    skr_d = skr_q; ski_d = ski_q; c_d = c_q; d_d = d_q;
    p_d = p_q;   q_d = q_q;
    unique case (state_q)
      SQ_IDLE: ;
      SQ_LOAD: begin
        cnt_d = '0;
        rem_d = '0;
        quo_d = '0;
        if (is_div) begin
          prod_d = {64'd0, mag_x} << 56;
          neg_d  = op_x[63];
        end else begin
          prod_d = {64'd0, mag_y};
          mx_d   = mag_x;
          neg_d  = op_x[63] ^ op_y[63];
        end
      end
      SQ_MUL: begin
        cnt_d  = cnt_q + 7'd1;
        prod_d = {mul_sum, prod_q[63:1]};
      end
      SQ_DIV: begin
        cnt_d  = cnt_q + 7'd1;
        prod_d = prod_q << 1;
        if (div_rem >= {1'b0, n_q}) begin
          rem_d = 64'(div_rem - {1'b0, n_q});
          quo_d = {quo_q[62:0], 1'b1};
        end else begin
          rem_d = div_rem[63:0];
          quo_d = {quo_q[62:0], 1'b0};
        end
      end
      SQ_STORE: begin
        unique case (step_q)
          ST_VRR:  acc_d = prod_s;
          ST_VII: begin
            n_d    = acc_q[63:0] + prod_s[63:0];
            zero_d = (n_d == '0);
          end
          ST_DIVA: a_d   = quo_s;
          ST_DIVB: b_d   = quo_s;
          ST_KA:   ka_d  = bcs_sat64(prod_s >>> 48);
          ST_KB:   kb_d  = bcs_sat64(prod_s >>> 48);
          ST_SKR:  skr_d = bcs_sat64(prod_s >>> 16);
          ST_SKI:  ski_d = bcs_sat64(prod_s >>> 16);
          ST_AA:   acc_d = prod_s;
          ST_BB:   c_d   = bcs_sat64((acc_q - prod_s) >>> 50);
          ST_AB:   d_d   = bcs_sat64(prod_s >>> 49);
          ST_P0:   acc_d = prod_s;
          ST_P1:   p_d   = bcs_sat64((-(acc_q + prod_s)) >>> 38);
          ST_Q0:   acc_d = prod_s;
          ST_Q1:   q_d   = bcs_sat64((acc_q - prod_s) >>> 38);
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SQ_LOAD;
      step_q  <= ST_VRR;
      zero_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      zero_q  <= zero_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cnt_q <= cnt_d;   prod_q <= prod_d; mx_q <= mx_d;   rem_q <= rem_d;
    quo_q <= quo_d;   neg_q <= neg_d;   n_q <= n_d;     acc_q <= acc_d;
    a_q <= a_d;       b_q <= b_d;       ka_q <= ka_d;   kb_q <= kb_d;
    skr_q <= skr_d;   ski_q <= ski_d;   c_q <= c_d;     d_q <= d_d;
    p_q <= p_d;       q_q <= q_d;
  end

  // outputs
  always_comb begin
    busy_o        = (state_q != SQ_IDLE);
    coef_o.ka     = ka_q;
    coef_o.kb     = kb_q;
    coef_o.p      = p_q;
    coef_o.q      = q_q;
    coef_o.ka_neg = -ka_q;
    coef_o.p_neg  = -p_q;
    coef_o.zero   = zero_q;
  end

endmodule

[sim/testbench.sv]
`timescale 1ns / 1ps
module testbench;
  import bcs_pkg::*;

  // Predicts current sensitivity results from the node registers and holds
  // the results still owed by the block, oldest first.
  class isens_scoreboard;
    logic [DATA_WIDTH-1:0] node_reg [4];
    bcs_out_t owed_q[$];
    int errors;
    int transfers_in;
    int transfers_out;
    int zero_v_seen;

    function new();
      node_reg[0] = 32'd65536;
      node_reg[1] = '0;
      node_reg[2] = '0;
      node_reg[3] = '0;
      errors = 0;
      transfers_in = 0;
      transfers_out = 0;
      zero_v_seen = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_WIDTH-1:0] idx, logic [DATA_WIDTH-1:0] val);
      if (idx <= REG_POWER_IM) node_reg[idx] = val;
    endfunction

    // Symmetric clip to +-(2^63-1).
    function logic signed [63:0] clip_coef(logic signed [127:0] x);
      logic signed [127:0] lim;
      lim = 128'sh7FFF_FFFF_FFFF_FFFF;
      if (x > lim) return lim[63:0];
      if (x < -lim) return -lim[63:0];
      return x[63:0];
    endfunction

    function logic signed [31:0] clip_out(logic signed [127:0] x);
      if (x > 128'sd2147483647) return 32'sh7FFF_FFFF;
      if (x < -128'sd2147483648) return 32'sh8000_0000;
      return x[31:0];
    endfunction

    // Truncated x * 2^56 / n, magnitude limited to 2^62.
    function logic signed [63:0] scaled_recip(logic signed [63:0] x, logic [63:0] n);
      logic [127:0] m;
      logic [127:0] quo;
      m = (x < 0) ? 128'(-x) : 128'(x);
      quo = (m << 56) / {64'd0, n};
      if (quo > (128'd1 << 62)) quo = 128'd1 << 62;
      return (x < 0) ? -(quo[63:0]) : quo[63:0];
    endfunction

    function logic signed [127:0] wmul(logic signed [127:0] x, logic signed [127:0] y);
      return x * y;
    endfunction

    function bcs_out_t predict(bcs_in_t d);
      bcs_out_t r;
      logic signed [63:0] vr, vi, sr, si, a, b, ka, kb, skr, ski, c, dd, p, q;
      logic signed [63:0] gm [4];
      logic signed [63:0] hm [4];
      logic signed [63:0] am [4];
      logic signed [63:0] bm [4];
      logic signed [127:0] k, acc;
      logic signed [31:0] res [4];
      logic [63:0] n;
      vr = $signed(node_reg[0]);
      vi = $signed(node_reg[1]);
      sr = $signed(node_reg[2]);
      si = $signed(node_reg[3]);
      n = vr * vr + vi * vi;
      r = '0;
      r.last_leaf_out = d.last_leaf_in;
      if (n == 0) begin
        r.zero_voltage = 1'b1;
        return r;
      end
      k = 128'sd2479700525;
      a = scaled_recip(vr, n);
      b = scaled_recip(vi, n);
      ka = clip_coef(wmul(a, k) >>> 48);
      kb = clip_coef(wmul(b, k) >>> 48);
      skr = clip_coef(wmul(sr, k) >>> 16);
      ski = clip_coef(wmul(si, k) >>> 16);
      c = clip_coef((wmul(a, a) - wmul(b, b)) >>> 50);
      dd = clip_coef(wmul(a, b) >>> 49);
      p = clip_coef((-(wmul(skr, c) + wmul(ski, dd))) >>> 38);
      q = clip_coef((wmul(ski, c) - wmul(skr, dd)) >>> 38);
      gm[0] = ka; gm[1] = kb; gm[2] = kb; gm[3] = -ka;
      hm[0] = p;  hm[1] = q;  hm[2] = q;  hm[3] = -p;
      am[0] = d.psens_00; am[1] = d.psens_01; am[2] = d.psens_10; am[3] = d.psens_11;
      bm[0] = d.vsens_00; bm[1] = d.vsens_01; bm[2] = d.vsens_10; bm[3] = d.vsens_11;
      for (int i = 0; i < 2; i++) begin
        for (int j = 0; j < 2; j++) begin
          acc = wmul(gm[2*i], am[j]) + wmul(gm[2*i+1], am[2+j])
              + wmul(hm[2*i], bm[j]) + wmul(hm[2*i+1], bm[2+j]);
          res[2*i+j] = clip_out(acc >>> 24);
        end
      end
      r.isens_00 = res[0];
      r.isens_01 = res[1];
      r.isens_10 = res[2];
      r.isens_11 = res[3];
      return r;
    endfunction

    function void note_input(bcs_in_t d);
      owed_q.push_back(predict(d));
      transfers_in++;
    endfunction

    function void field_cmp(string name, logic [31:0] e, logic [31:0] g);
      if (e !== g) begin
        $display("%0t: mismatch %s expected %h actual %h", $time, name, e, g);
        errors++;
      end
    endfunction

    function void check_result(bcs_out_t got);
      bcs_out_t e;
      transfers_out++;
      if (owed_q.size() == 0) begin
        $display("%0t: unexpected result, expected none actual %h", $time, got);
        errors++;
        return;
      end
      e = owed_q.pop_front();
      if (e.zero_voltage) zero_v_seen++;
      field_cmp("isens_00", e.isens_00, got.isens_00);
      field_cmp("isens_01", e.isens_01, got.isens_01);
      field_cmp("isens_10", e.isens_10, got.isens_10);
      field_cmp("isens_11", e.isens_11, got.isens_11);
      field_cmp("last_leaf_out", 32'(e.last_leaf_out), 32'(got.last_leaf_out));
      field_cmp("zero_voltage", 32'(e.zero_voltage), 32'(got.zero_voltage));
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  logic in_valid_i;
  logic in_stall_o;
  bcs_in_t in_data_i;
  logic out_valid_o;
  logic out_stall_i;
  bcs_out_t out_data_o;
  logic cfg_valid_i;
  logic cfg_ready_o;
  logic [CFG_IDX_WIDTH-1:0] cfg_index_i;
  logic [DATA_WIDTH-1:0] cfg_data_i;

  isens_scoreboard sb;
  int sender_idle_pct;
  int recv_stall_pct;

  branch_current_sensitivity_top i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Receiver side: stall at the rate of the current phase.
  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < recv_stall_pct);
  end

  // Watch both channels; values read here are the ones present at the edge.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) sb.note_input(in_data_i);
      if (out_valid_o && !out_stall_i) sb.check_result(out_data_o);
    end
  end

  // Hold the payload until the transfer completes; idle first at the phase rate.
  task automatic send_leaf(bcs_in_t d);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= d;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  // Leave valid high so that writes can follow back to back; the caller drops it.
  task automatic write_node_reg(logic [CFG_IDX_WIDTH-1:0] idx, logic [DATA_WIDTH-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    sb.write_reg(idx, val);
  endtask

  // Let every owed result arrive, then give the pipeline its latency to settle.
  task automatic drain;
    in_valid_i <= 1'b0;
    while (sb.owed_q.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
  endtask

  // Mix full-range words, arithmetically shifted smaller words, extremes and zero.
  function automatic logic [31:0] rand_word();
    case ($urandom_range(5))
      0, 1: return $urandom;
      2, 3: return $signed($urandom) >>> $urandom_range(4, 12);
      4: return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      default: return '0;
    endcase
  endfunction

  function automatic bcs_in_t rand_leaf();
    bcs_in_t d;
    d.psens_00 = rand_word(); d.psens_01 = rand_word();
    d.psens_10 = rand_word(); d.psens_11 = rand_word();
    d.vsens_00 = rand_word(); d.vsens_01 = rand_word();
    d.vsens_10 = rand_word(); d.vsens_11 = rand_word();
    d.last_leaf_in = ($urandom_range(7) == 0);
    return d;
  endfunction

  function automatic bcs_in_t fill_leaf(logic [31:0] pa, logic [31:0] vb, logic last);
    bcs_in_t d;
    d.psens_00 = pa; d.psens_01 = pa; d.psens_10 = pa; d.psens_11 = pa;
    d.vsens_00 = vb; d.vsens_01 = vb; d.vsens_10 = vb; d.vsens_11 = vb;
    d.last_leaf_in = last;
    return d;
  endfunction

  task automatic load_node(logic [31:0] vr, logic [31:0] vi, logic [31:0] sr,
                           logic [31:0] si);
    write_node_reg(REG_VOLTAGE_RE, vr);
    write_node_reg(REG_VOLTAGE_IM, vi);
    write_node_reg(REG_POWER_RE, sr);
    write_node_reg(REG_POWER_IM, si);
  endtask

  task automatic directed_leaves();
    bcs_in_t d;
    send_leaf(fill_leaf(32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0));
    send_leaf(fill_leaf(32'h8000_0000, 32'h8000_0000, 1'b1));
    send_leaf(fill_leaf(32'h0, 32'h0, 1'b0));
    send_leaf(fill_leaf(32'h7FFF_FFFF, 32'h8000_0000, 1'b1));
    send_leaf(fill_leaf(32'hFFFF_FFFF, 32'h0000_0001, 1'b0));
    d = fill_leaf(32'h0, 32'h0, 1'b1);
    d.psens_00 = 32'h0100_0000;
    d.psens_11 = 32'h0100_0000;
    d.vsens_01 = 32'hFF00_0000;
    send_leaf(d);
  endtask

  initial begin
    int phase;
    int n_rand;
    logic [31:0] vr, vi;
    sb = new();
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_data_i = '0;
    out_stall_i = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i = '0;
    sender_idle_pct = 0;
    recv_stall_pct = 0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset setting: unit voltage, no power.
    directed_leaves();
    drain();

    for (phase = 0; phase < 12; phase++) begin
      case (phase % 4)
        0: begin sender_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin sender_idle_pct = 70; recv_stall_pct = 0;  end
        2: begin sender_idle_pct = 0;  recv_stall_pct = 70; end
        default: begin sender_idle_pct = 7; recv_stall_pct = 7; end
      endcase
      vr = $signed($urandom) >>> $urandom_range(8, 31);
      vi = $signed($urandom) >>> $urandom_range(8, 31);
      case (phase)
        0: load_node(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
        1: load_node(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF);
        2: load_node(32'h0, 32'h0, $urandom, $urandom);
        // Tiny voltage drives the coefficients into saturation.
        3: load_node(32'h1, 32'h0, $urandom, $urandom);
        4: load_node(32'hFFFF_FFFF, 32'h1, 32'h0001_0000, 32'hFFFF_0000);
        5: load_node(32'h0001_0000 + ($signed($urandom) >>> 20), $signed($urandom) >>> 20,
                     $signed($urandom) >>> 12, $signed($urandom) >>> 12);
        default: load_node(vr, vi, $signed($urandom) >>> $urandom_range(0, 20),
                           $signed($urandom) >>> $urandom_range(0, 20));
      endcase
      // An unknown index must leave the node untouched.
      if (phase % 3 == 1) write_node_reg(CFG_IDX_WIDTH'($urandom_range(4, 255)), $urandom);
      cfg_valid_i <= 1'b0;
      if (phase < 2) directed_leaves();
      n_rand = 128;
      repeat (n_rand) send_leaf(rand_leaf());
      drain();
    end

    $display("covered %0d leaf transfers over 13 node settings, %0d with zero voltage",
             sb.transfers_in, sb.zero_v_seen);
    $display("idling phases: none, sender 70%%, receiver 70%%, both 7%%");
    if (sb.errors == 0 && sb.owed_q.size() == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("timeout with %0d results outstanding", sb.owed_q.size());
    $display("testbench: errors");
    $finish;
  end

endmodule

[filelist.f]
rtl/core/bcs_pkg.sv
rtl/core/bcs_coef.sv
rtl/core/branch_current_sensitivity_top.sv
sim/testbench.sv
